// ----- src/fft_pkg.sv -----
package fft_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_READ = 2'd1,
    CMD_RUN  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  typedef enum logic {
    KIND_DONE = 1'b0,
    KIND_BIN  = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    BF_HOLD,
    BF_M0,
    BF_M1,
    BF_M2,
    BF_M3,
    BF_M4,
    BF_RND
  } bfly_step_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_REV_RD,
    ST_REV_WA,
    ST_REV_WB,
    ST_BF_RD,
    ST_M0,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_RND,
    ST_BF_WA,
    ST_BF_WB,
    ST_DONE
  } state_t;

  // 2*pi in q60
  localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;

  // (a*b) >> 60, low 64 bits
  function automatic logic [63:0] mul_q60(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[123:60];
  endfunction

  // {sin, cos} in q60 of x in q60, taylor series of 14 terms
  function automatic logic [127:0] sin_cos_q60(logic [63:0] x);
    logic [63:0] x2;
    logic [63:0] ts;
    logic [63:0] tc;
    logic [63:0] sv;
    logic [63:0] cv;
    x2 = mul_q60(x, x);
    ts = x;
    tc = 64'd1 << 60;
    sv = x;
    cv = tc;
    for (int n = 1; n <= 13; n++) begin
      ts = mul_q60(ts, x2) / 64'((2 * n) * (2 * n + 1));
      tc = mul_q60(tc, x2) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        sv = sv - ts;
        cv = cv - tc;
      end else begin
        sv = sv + ts;
        cv = cv + tc;
      end
    end
    return {sv, cv};
  endfunction

  function automatic logic [31:0] quantize(logic signed [63:0] v, int tbits);
    logic signed [63:0] r;
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    r  = (v + (64'sd1 <<< (60 - tbits))) >>> (61 - tbits);
    hi = (64'sd1 <<< (tbits - 1)) - 64'sd1;
    lo = -(64'sd1 <<< (tbits - 1));
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r[31:0];
  endfunction

  // elaboration-time twiddle: cos or -sin of 2*pi*k/2^log2p
  function automatic logic [31:0] twiddle(int k, int log2p, int tbits, bit want_cos);
    logic [63:0] step;
    logic [127:0] sc;
    logic signed [63:0] s;
    logic signed [63:0] c;
    int quarter;
    quarter = 1 << (log2p - 2);
    step = TWO_PI_Q60 >> log2p;
    if (k < quarter) begin
      sc = sin_cos_q60(step * 64'(k));
      s = sc[127:64];
      c = sc[63:0];
      return want_cos ? quantize(c, tbits) : quantize(-s, tbits);
    end
    sc = sin_cos_q60(step * 64'(k - quarter));
    s = sc[127:64];
    c = sc[63:0];
    return want_cos ? quantize(-s, tbits) : quantize(-c, tbits);
  endfunction

endpackage

// ----- src/fft_rom.sv -----
module fft_rom #(
  parameter int POINTS       = 1024,
  parameter int TWIDDLE_BITS = 18
) (
  input  logic                           clk,
  input  logic                           rd_en,
  input  logic [$clog2(POINTS)-2:0]      rd_addr,
  output logic signed [TWIDDLE_BITS-1:0] cos_q,
  output logic signed [TWIDDLE_BITS-1:0] msin_q
);

  localparam int AW   = $clog2(POINTS);
  localparam int HALF = POINTS / 2;

  logic signed [TWIDDLE_BITS-1:0] cos_tab  [HALF];
  logic signed [TWIDDLE_BITS-1:0] msin_tab [HALF];

  for (genvar g = 0; g < HALF; g++) begin : g_tab
    localparam logic [31:0] C = fft_pkg::twiddle(g, AW, TWIDDLE_BITS, 1'b1);
    localparam logic [31:0] S = fft_pkg::twiddle(g, AW, TWIDDLE_BITS, 1'b0);
    assign cos_tab[g]  = C[TWIDDLE_BITS-1:0];
    assign msin_tab[g] = S[TWIDDLE_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      cos_q  <= cos_tab[rd_addr];
      msin_q <= msin_tab[rd_addr];
    end
  end

endmodule

// ----- src/fft_mem.sv -----
module fft_mem #(
  parameter int AW = 10
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output logic [63:0]   rd_data_a,
  output logic [63:0]   rd_data_b,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [63:0]   wr_data
);

  // word is {re, im}
  logic [63:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

// ----- src/fft_bfly.sv -----
module fft_bfly #(
  parameter int TWIDDLE_BITS = 18
) (
  input  logic                           clk,
  input  fft_pkg::bfly_step_t            step,
  input  logic [63:0]                    u_word,
  input  logic [63:0]                    v_word,
  input  logic signed [TWIDDLE_BITS-1:0] w_re,
  input  logic signed [TWIDDLE_BITS-1:0] w_im,
  output logic [63:0]                    sum_word,
  output logic [63:0]                    dif_word
);

  localparam int PW  = 32 + TWIDDLE_BITS;
  localparam int ACC = PW + 2;

  logic signed [31:0]              xr;
  logic signed [31:0]              xi;
  logic signed [31:0]              a_op;
  logic signed [TWIDDLE_BITS-1:0]  b_op;
  logic signed [PW-1:0]            prod_r;
  logic signed [ACC-1:0]           acc_re_r;
  logic signed [ACC-1:0]           acc_im_r;
  logic signed [ACC-1:0]           rnd_re;
  logic signed [ACC-1:0]           rnd_im;
  logic [31:0]                     pr_r;
  logic [31:0]                     pi_r;

  assign xr = v_word[63:32];
  assign xi = v_word[31:0];

  // one multiplier, four products per butterfly
  always_comb begin
    case (step)
      fft_pkg::BF_M1: begin
        a_op = xi;
        b_op = w_im;
      end
      fft_pkg::BF_M2: begin
        a_op = xr;
        b_op = w_im;
      end
      fft_pkg::BF_M3: begin
        a_op = xi;
        b_op = w_re;
      end
      default: begin
        a_op = xr;
        b_op = w_re;
      end
    endcase
  end

  assign rnd_re = (acc_re_r + (ACC'(1) <<< (TWIDDLE_BITS - 2))) >>> (TWIDDLE_BITS - 1);
  assign rnd_im = (acc_im_r + (ACC'(1) <<< (TWIDDLE_BITS - 2))) >>> (TWIDDLE_BITS - 1);

  always_ff @(posedge clk) begin
    case (step)
      fft_pkg::BF_M0: begin
        prod_r <= a_op * b_op;
      end
      fft_pkg::BF_M1: begin
        acc_re_r <= ACC'(prod_r);
        prod_r   <= a_op * b_op;
      end
      fft_pkg::BF_M2: begin
        acc_re_r <= acc_re_r - ACC'(prod_r);
        prod_r   <= a_op * b_op;
      end
      fft_pkg::BF_M3: begin
        acc_im_r <= ACC'(prod_r);
        prod_r   <= a_op * b_op;
      end
      fft_pkg::BF_M4: begin
        acc_im_r <= acc_im_r + ACC'(prod_r);
      end
      fft_pkg::BF_RND: begin
        pr_r <= rnd_re[31:0];
        pi_r <= rnd_im[31:0];
      end
      default: begin
      end
    endcase
  end

  assign sum_word = {u_word[63:32] + pr_r, u_word[31:0] + pi_r};
  assign dif_word = {u_word[63:32] - pr_r, u_word[31:0] - pi_r};

endmodule

// ----- src/radix2_fft_engine.sv -----
// in-place radix-2 fft engine on one command channel and one result channel
// in_command: load writes a q1.15 sample pair at in_index (widened to q11.21),
// read returns the stored bin at in_index, run transforms the whole store,
// the unused code is taken and dropped
// a load writes the store when taken; a read loads the stored word into the
// store's read register and then into the output register as kind=bin
// a run does the bit-reverse pass (reads each index pair, writes swapped pairs
// back), then log2(POINTS) stages of POINTS/2 butterflies, each a read, the
// steps M0..M4, since one multiplier forms the four products of a butterfly in
// turn, a round and two writes; then a kind=done word with zero bins follows
// in_stall is high while a run or a read is in progress, and while a result
// waits in the output register and out_stall holds it
// reset clears the sequencer state and the output valid flag; the sample store is
// not cleared, so only loaded entries may be read or transformed
module radix2_fft_engine #(
  parameter int POINTS       = 1024,
  parameter int TWIDDLE_BITS = 18
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_command,
  input  logic [9:0]         in_index,
  input  logic signed [15:0] in_sample_re,
  input  logic signed [15:0] in_sample_im,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_kind,
  output logic signed [31:0] out_bin_re,
  output logic signed [31:0] out_bin_im
);

  localparam int AW = $clog2(POINTS);
  localparam int SW = $clog2(AW);
  localparam logic [SW-1:0] LAST_STAGE = SW'(AW - 1);

  fft_pkg::state_t     state_r, state_nxt;
  fft_pkg::bfly_step_t step;

  logic [AW-1:0]   i_r, i_nxt;
  logic [AW-2:0]   b_r, b_nxt;
  logic [SW-1:0]   s_r, s_nxt;
  logic            rd_pend_r, rd_pend_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_kind_r;
  logic [31:0]     out_re_r;
  logic [31:0]     out_im_r;
  logic            out_load;
  logic            out_load_bin;
  logic            out_free;
  logic            accept;
  logic [AW-1:0]   idx;
  logic [AW-1:0]   rev_i;
  logic [AW-2:0]   half_mask;
  logic [AW-2:0]   bl;
  logic [AW-1:0]   u_addr;
  logic [AW-1:0]   v_addr;
  logic [AW-2:0]   k_addr;

  logic            mem_ren;
  logic [AW-1:0]   mem_ra;
  logic [AW-1:0]   mem_rb;
  logic [63:0]     mem_qa;
  logic [63:0]     mem_qb;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  logic [63:0]     mem_wd;
  logic            rom_ren;
  logic signed [TWIDDLE_BITS-1:0] w_re;
  logic signed [TWIDDLE_BITS-1:0] w_im;
  logic [63:0]     sum_word;
  logic [63:0]     dif_word;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = !(state_r == fft_pkg::ST_IDLE && !rd_pend_r && out_free);
  assign accept   = in_valid && !in_stall;
  assign idx      = AW'(in_index);

  always_comb begin
    for (int n = 0; n < AW; n++) begin
      rev_i[n] = i_r[AW-1-n];
    end
  end

  // u has a zero inserted at bit s of the butterfly count, v has a one there
  assign half_mask = ~({(AW-1){1'b1}} << s_r);
  assign bl        = b_r & half_mask;
  assign u_addr    = (AW'(b_r & ~half_mask) << 1) | AW'(bl);
  assign v_addr    = u_addr | (AW'(1) << s_r);
  assign k_addr    = bl << (LAST_STAGE - s_r);

  fft_mem #(.AW(AW)) u_mem (
    .clk       (clk),
    .rd_en     (mem_ren),
    .rd_addr_a (mem_ra),
    .rd_addr_b (mem_rb),
    .rd_data_a (mem_qa),
    .rd_data_b (mem_qb),
    .wr_en     (mem_we),
    .wr_addr   (mem_wa),
    .wr_data   (mem_wd)
  );

  fft_rom #(.POINTS(POINTS), .TWIDDLE_BITS(TWIDDLE_BITS)) u_rom (
    .clk     (clk),
    .rd_en   (rom_ren),
    .rd_addr (k_addr),
    .cos_q   (w_re),
    .msin_q  (w_im)
  );

  fft_bfly #(.TWIDDLE_BITS(TWIDDLE_BITS)) u_bfly (
    .clk      (clk),
    .step     (step),
    .u_word   (mem_qa),
    .v_word   (mem_qb),
    .w_re     (w_re),
    .w_im     (w_im),
    .sum_word (sum_word),
    .dif_word (dif_word)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= fft_pkg::ST_IDLE;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    b_r <= b_nxt;
    s_r <= s_nxt;
    if (out_load) begin
      out_kind_r <= out_load_bin ? fft_pkg::KIND_BIN : fft_pkg::KIND_DONE;
      out_re_r   <= out_load_bin ? mem_qa[63:32] : 32'd0;
      out_im_r   <= out_load_bin ? mem_qa[31:0] : 32'd0;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    i_nxt        = i_r;
    b_nxt        = b_r;
    s_nxt        = s_r;
    rd_pend_nxt  = 1'b0;
    mem_ren      = 1'b0;
    mem_ra       = idx;
    mem_rb       = idx;
    mem_we       = 1'b0;
    mem_wa       = idx;
    mem_wd       = {{10{in_sample_re[15]}}, in_sample_re, 6'd0,
                    {10{in_sample_im[15]}}, in_sample_im, 6'd0};
    rom_ren      = 1'b0;
    step         = fft_pkg::BF_HOLD;
    out_load     = rd_pend_r;
    out_load_bin = rd_pend_r;

    unique case (state_r)
      fft_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (fft_pkg::cmd_t'(in_command))
            fft_pkg::CMD_LOAD: mem_we = 1'b1;
            fft_pkg::CMD_READ: begin
              mem_ren     = 1'b1;
              rd_pend_nxt = 1'b1;
            end
            fft_pkg::CMD_RUN: begin
              i_nxt     = '0;
              state_nxt = fft_pkg::ST_REV_RD;
            end
            default: begin
            end
          endcase
        end
      end
      fft_pkg::ST_REV_RD: begin
        mem_ren = 1'b1;
        mem_ra  = i_r;
        mem_rb  = rev_i;
        if (i_r < rev_i) begin
          state_nxt = fft_pkg::ST_REV_WA;
        end else if (&i_r) begin
          b_nxt     = '0;
          s_nxt     = '0;
          state_nxt = fft_pkg::ST_BF_RD;
        end else begin
          i_nxt = i_r + AW'(1);
        end
      end
      fft_pkg::ST_REV_WA: begin
        mem_we    = 1'b1;
        mem_wa    = i_r;
        mem_wd    = mem_qb;
        state_nxt = fft_pkg::ST_REV_WB;
      end
      fft_pkg::ST_REV_WB: begin
        mem_we    = 1'b1;
        mem_wa    = rev_i;
        mem_wd    = mem_qa;
        // a swapped i is never the last index
        i_nxt     = i_r + AW'(1);
        state_nxt = fft_pkg::ST_REV_RD;
      end
      fft_pkg::ST_BF_RD: begin
        mem_ren   = 1'b1;
        mem_ra    = u_addr;
        mem_rb    = v_addr;
        rom_ren   = 1'b1;
        state_nxt = fft_pkg::ST_M0;
      end
      fft_pkg::ST_M0: begin
        step      = fft_pkg::BF_M0;
        state_nxt = fft_pkg::ST_M1;
      end
      fft_pkg::ST_M1: begin
        step      = fft_pkg::BF_M1;
        state_nxt = fft_pkg::ST_M2;
      end
      fft_pkg::ST_M2: begin
        step      = fft_pkg::BF_M2;
        state_nxt = fft_pkg::ST_M3;
      end
      fft_pkg::ST_M3: begin
        step      = fft_pkg::BF_M3;
        state_nxt = fft_pkg::ST_M4;
      end
      fft_pkg::ST_M4: begin
        step      = fft_pkg::BF_M4;
        state_nxt = fft_pkg::ST_RND;
      end
      fft_pkg::ST_RND: begin
        step      = fft_pkg::BF_RND;
        state_nxt = fft_pkg::ST_BF_WA;
      end
      fft_pkg::ST_BF_WA: begin
        mem_we    = 1'b1;
        mem_wa    = u_addr;
        mem_wd    = sum_word;
        state_nxt = fft_pkg::ST_BF_WB;
      end
      fft_pkg::ST_BF_WB: begin
        mem_we = 1'b1;
        mem_wa = v_addr;
        mem_wd = dif_word;
        if (&b_r) begin
          b_nxt = '0;
          if (s_r == LAST_STAGE) begin
            state_nxt = fft_pkg::ST_DONE;
          end else begin
            s_nxt     = s_r + SW'(1);
            state_nxt = fft_pkg::ST_BF_RD;
          end
        end else begin
          b_nxt     = b_r + (AW-1)'(1);
          state_nxt = fft_pkg::ST_BF_RD;
        end
      end
      fft_pkg::ST_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = fft_pkg::ST_IDLE;
        end
      end
      default: state_nxt = fft_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_kind   = out_kind_r;
  assign out_bin_re = out_re_r;
  assign out_bin_im = out_im_r;

endmodule
